>>> hdl/rmlu_pkg.sv
// rmlu_pkg: command and status codes and field widths of the monitor lock unit
// no dependencies; used by the interfaces and the top level
`default_nettype none

package rmlu_pkg;

  // widths of the item fields
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned TID_W    = 4;
  localparam int unsigned MID_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned MOVED_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENTER   = 3'd0,
    CMD_EXIT    = 3'd1,
    CMD_WAIT    = 3'd2,
    CMD_NOT_ONE = 3'd3,
    CMD_NOT_ALL = 3'd4,
    CMD_TRY     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_NOT_OWNER = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_WAITING   = 3'd5,
    ST_NONE      = 3'd6
  } status_e;

endpackage

`default_nettype wire

>>> hdl/rmlu_if.sv
// rmlu_req_if and rmlu_rsp_if: valid/ready channels of the monitor lock unit
// depends on rmlu_pkg for the field widths
`default_nettype none

interface rmlu_req_if;
  import rmlu_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [TID_W-1:0]   thread_id;
  logic [MID_W-1:0]   monitor_id;
  modport source (output valid, command, thread_id, monitor_id, input ready);
  modport sink   (input valid, command, thread_id, monitor_id, output ready);
endinterface

interface rmlu_rsp_if;
  import rmlu_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  hold_count;
  logic [MOVED_W-1:0]  notified_count;
  logic [COUNT_W-1:0]  released_count;
  modport source (output valid, status, hold_count, notified_count, released_count,
                  input ready);
  modport sink   (input valid, status, hold_count, notified_count, released_count,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/rmlu_ram.sv
// rmlu_ram: one write port, one read port memory with registered read data
// no dependencies
`default_nettype none

module rmlu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/reentrant_monitor_lock_unit.sv
// reentrant_monitor_lock_unit: lock manager for reentrant monitors with wait and notify
// depends on rmlu_pkg, rmlu_req_if, rmlu_rsp_if and rmlu_ram
//
// Usage: a request item (command, thread_id, monitor_id) enters on req_i, and
// every request gives exactly one response item (status, hold_count,
// notified_count, released_count) on rsp_o. One request is worked on at a time.
// Per-monitor owner and hold count live in one memory, per-thread lock-pending,
// notify-pending and saved count in another; each request reads, decides and
// writes back. Bad commands and reserved ids go straight to the response;
// enter, exit and wait read both memories once; try acquire also looks up
// the pending monitor when there is one, and notify walks the thread memory
// one slot per cycle from the highest slot down. Once the response is loaded
// into the output register the unit returns to idle and takes a new request.
// After reset both memories are cleared in a pass over max(THREAD_SLOTS,
// MONITOR_SLOTS) addresses during which no request is taken.
// A stalled response holds in the output register; the unit then waits with
// its next response until the output register is free.
`default_nettype none

module reentrant_monitor_lock_unit #(
  parameter int unsigned THREAD_SLOTS  = 16,
  parameter int unsigned MONITOR_SLOTS = 256,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rmlu_req_if.sink   req_i,
  rmlu_rsp_if.source rsp_o
);

  import rmlu_pkg::*;

  localparam int unsigned TW   = $clog2(THREAD_SLOTS);
  localparam int unsigned MW   = $clog2(MONITOR_SLOTS);
  localparam int unsigned MAXS = (THREAD_SLOTS > MONITOR_SLOTS) ? THREAD_SLOTS
                                                                : MONITOR_SLOTS;
  localparam int unsigned CW   = $clog2(MAXS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    logic [TW-1:0]         owner;
    logic [COUNT_BITS-1:0] holds;
  } mon_t;

  typedef struct packed {
    logic [MW-1:0]         lock;
    logic [MW-1:0]         notify;
    logic [COUNT_BITS-1:0] saved;
  } thr_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_EXEC, S_TRY, S_SCAN, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [TW-1:0] t_q, t_d;
  logic [MW-1:0] m_q, m_d;
  logic [TW-1:0] idx_q, idx_d, chk_idx_q, chk_idx_d;
  logic issue_q, issue_d, chk_q, chk_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [COUNT_BITS-1:0] hc_q, hc_d, rc_q, rc_d;
  logic [MOVED_W-1:0] nc_q, nc_d;
  logic out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;
  logic [COUNT_W-1:0] out_hc_q, out_hc_d, out_rc_q, out_rc_d;
  logic [MOVED_W-1:0] out_nc_q, out_nc_d;

  // memory ports
  logic mon_we, thr_we;
  logic [MW-1:0] mon_wa, mon_ra;
  logic [TW-1:0] thr_wa, thr_ra;
  mon_t mon_wd, mon_rd;
  thr_t thr_wd, thr_rd;

  logic [TW-1:0] in_t;
  logic [MW-1:0] in_m;
  logic accept;

  assign in_t   = TW'(req_i.thread_id % THREAD_SLOTS);
  assign in_m   = MW'(req_i.monitor_id % MONITOR_SLOTS);
  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_st_q;
  assign rsp_o.hold_count     = out_hc_q;
  assign rsp_o.notified_count = out_nc_q;
  assign rsp_o.released_count = out_rc_q;

  rmlu_ram #(.WIDTH($bits(mon_t)), .DEPTH(MONITOR_SLOTS)) u_mon_ram (
    .clk_i   (clk_i),
    .we_i    (mon_we),
    .waddr_i (mon_wa),
    .wdata_i (mon_wd),
    .raddr_i (mon_ra),
    .rdata_o (mon_rd)
  );

  rmlu_ram #(.WIDTH($bits(thr_t)), .DEPTH(THREAD_SLOTS)) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_wa),
    .wdata_i (thr_wd),
    .raddr_i (thr_ra),
    .rdata_o (thr_rd)
  );

  // control, decisions and write-back
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    t_d         = t_q;
    m_d         = m_q;
    idx_d       = idx_q;
    chk_idx_d   = chk_idx_q;
    issue_d     = issue_q;
    chk_d       = 1'b0;
    st_d        = st_q;
    hc_d        = hc_q;
    nc_d        = nc_q;
    rc_d        = rc_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_st_d    = out_st_q;
    out_hc_d    = out_hc_q;
    out_nc_d    = out_nc_q;
    out_rc_d    = out_rc_q;
    mon_we      = 1'b0;
    mon_wa      = m_q;
    mon_wd      = mon_rd;
    mon_ra      = in_m;
    thr_we      = 1'b0;
    thr_wa      = t_q;
    thr_wd      = thr_rd;
    thr_ra      = in_t;

    case (state_q)
      // clear both memories after reset
      S_CLR: begin
        mon_wa = MW'(cnt_q);
        thr_wa = TW'(cnt_q);
        mon_wd = '0;
        thr_wd = '0;
        mon_we = ({1'b0, cnt_q} < (CW+1)'(MONITOR_SLOTS));
        thr_we = ({1'b0, cnt_q} < (CW+1)'(THREAD_SLOTS));
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CW'(MAXS - 1)) begin
          state_d = S_IDLE;
        end
      end

      // take a request, sort out the cases that need no lookup
      S_IDLE: begin
        if (accept) begin
          cmd_d = req_i.command;
          t_d   = in_t;
          m_d   = in_m;
          st_d  = ST_OK;
          hc_d  = '0;
          nc_d  = '0;
          rc_d  = '0;
          state_d = S_EXEC;
          if (req_i.command > CMD_TRY) begin
            state_d = S_OUT;
          end else if (in_t == '0) begin
            st_d    = ST_NOT_OWNER;
            state_d = S_OUT;
          end else if (req_i.command != CMD_TRY && in_m == '0) begin
            st_d    = ST_NOT_OWNER;
            state_d = S_OUT;
          end
        end
      end

      // monitor and thread entries are read; decide and write back
      S_EXEC: begin
        state_d = S_OUT;
        hc_d    = mon_rd.holds;
        // keep the own thread entry on the read port for try acquire
        thr_ra  = t_q;
        if (cmd_q == CMD_TRY) begin
          hc_d = '0;
          if (thr_rd.notify != '0) begin
            st_d = ST_WAITING;
          end else if (thr_rd.lock == '0) begin
            st_d = ST_NONE;
          end else begin
            mon_ra  = thr_rd.lock;
            m_d     = thr_rd.lock;
            state_d = S_TRY;
          end
        end else if (thr_rd.lock != '0 || thr_rd.notify != '0) begin
          st_d = ST_WAITING;
        end else begin
          case (cmd_e'(cmd_q))
            CMD_ENTER: begin
              if (mon_rd.owner == t_q) begin
                if (mon_rd.holds == CNT_MAX) begin
                  st_d = ST_OVERFLOW;
                end else begin
                  mon_we       = 1'b1;
                  mon_wd.holds = mon_rd.holds + CNT_ONE;
                  hc_d         = mon_rd.holds + CNT_ONE;
                end
              end else if (mon_rd.owner == '0) begin
                mon_we       = 1'b1;
                mon_wd.owner = t_q;
                mon_wd.holds = CNT_ONE;
                hc_d         = CNT_ONE;
              end else begin
                thr_we       = 1'b1;
                thr_wd.lock  = m_q;
                thr_wd.saved = CNT_ONE;
                st_d         = ST_QUEUED;
              end
            end
            default: begin
              if (mon_rd.owner != t_q) begin
                st_d = ST_NOT_OWNER;
              end else if (cmd_e'(cmd_q) == CMD_EXIT) begin
                if (mon_rd.holds == '0) begin
                  st_d = ST_UNDERFLOW;
                  hc_d = '0;
                end else begin
                  mon_we       = 1'b1;
                  mon_wd.holds = mon_rd.holds - CNT_ONE;
                  if (mon_rd.holds == CNT_ONE) begin
                    mon_wd.owner = '0;
                  end
                  hc_d = mon_rd.holds - CNT_ONE;
                end
              end else if (cmd_e'(cmd_q) == CMD_WAIT) begin
                thr_we        = 1'b1;
                thr_wd.saved  = mon_rd.holds;
                thr_wd.notify = m_q;
                mon_we        = 1'b1;
                mon_wd        = '0;
                hc_d          = '0;
                rc_d          = mon_rd.holds;
              end else begin
                // notify: walk thread slots from the top
                idx_d   = TW'(THREAD_SLOTS - 1);
                issue_d = 1'b1;
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end

      // pending monitor entry is read; grant if free
      S_TRY: begin
        state_d = S_OUT;
        if (mon_rd.owner != '0) begin
          st_d = ST_WAITING;
          hc_d = mon_rd.holds;
        end else begin
          mon_we       = 1'b1;
          mon_wd.owner = t_q;
          mon_wd.holds = thr_rd.saved;
          thr_we       = 1'b1;
          thr_wd.lock  = '0;
          hc_d         = thr_rd.saved;
        end
      end

      // one slot read per cycle, the slot read last cycle is checked
      S_SCAN: begin
        thr_ra    = idx_q;
        chk_idx_d = idx_q;
        chk_d     = issue_q;
        if (issue_q) begin
          if (idx_q == '0) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q - TW'(1);
          end
        end
        if (chk_q) begin
          thr_wa = chk_idx_q;
          if (thr_rd.notify == m_q) begin
            thr_we        = 1'b1;
            thr_wd.notify = '0;
            thr_wd.lock   = m_q;
            if (nc_q != '1) begin
              nc_d = nc_q + MOVED_W'(1);
            end
            if (cmd_e'(cmd_q) == CMD_NOT_ONE) begin
              state_d = S_OUT;
              chk_d   = 1'b0;
            end
          end
          if (chk_idx_q == '0) begin
            state_d = S_OUT;
            chk_d   = 1'b0;
          end
        end
      end

      // hand the response to the output register
      S_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_hc_d    = COUNT_W'(hc_q);
          out_nc_d    = nc_q;
          out_rc_d    = COUNT_W'(rc_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    t_q       <= t_d;
    m_q       <= m_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    st_q      <= st_d;
    hc_q      <= hc_d;
    nc_q      <= nc_d;
    rc_q      <= rc_d;
    out_st_q  <= out_st_d;
    out_hc_q  <= out_hc_d;
    out_nc_q  <= out_nc_d;
    out_rc_q  <= out_rc_d;
  end

endmodule

`default_nettype wire

>>> verif/rmlu_scoreboard.sv
// rmlu_scoreboard: predicts lock unit responses and checks them in order
// depends on rmlu_pkg for command and status codes and field widths
`timescale 1ns / 100ps

package rmlu_scoreboard_pkg;
  import rmlu_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  hold_count;
    logic [MOVED_W-1:0]  notified_count;
    logic [COUNT_W-1:0]  released_count;
  } lock_rsp_t;

  class lock_scoreboard;
    logic [TID_W-1:0]   owner_q [256];
    logic [COUNT_W-1:0] holds_q [256];
    logic [MID_W-1:0]   lock_pend_q [16];
    logic [MID_W-1:0]   notify_pend_q [16];
    logic [COUNT_W-1:0] saved_q [16];
    lock_rsp_t          pending_rsp_q [$];
    int                 errors;

    function new();
      errors = 0;
      foreach (owner_q[i]) begin
        owner_q[i] = '0;
        holds_q[i] = '0;
      end
      foreach (saved_q[i]) begin
        lock_pend_q[i] = '0;
        notify_pend_q[i] = '0;
        saved_q[i] = '0;
      end
    endfunction

    // compute the response of one accepted request and update the lock state
    function void note_request(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] t,
                               logic [MID_W-1:0] m);
      lock_rsp_t r;
      logic [MID_W-1:0] lp;
      logic [MOVED_W-1:0] moved;
      r = '0;
      if (cmd > CMD_TRY) begin
        r = '0;
      end else if (t == 0) begin
        r.status = ST_NOT_OWNER;
      end else if (cmd == CMD_TRY) begin
        lp = lock_pend_q[t];
        if (notify_pend_q[t] != 0) r.status = ST_WAITING;
        else if (lp == 0) r.status = ST_NONE;
        else if (owner_q[lp] != 0) begin
          r.status = ST_WAITING;
          r.hold_count = holds_q[lp];
        end else begin
          owner_q[lp] = t;
          holds_q[lp] = saved_q[t];
          lock_pend_q[t] = '0;
          r.status = ST_OK;
          r.hold_count = holds_q[lp];
        end
      end else if (m == 0) begin
        r.status = ST_NOT_OWNER;
      end else if (lock_pend_q[t] != 0 || notify_pend_q[t] != 0) begin
        r.status = ST_WAITING;
        r.hold_count = holds_q[m];
      end else if (cmd == CMD_ENTER) begin
        if (owner_q[m] == t) begin
          if (holds_q[m] == '1) r.status = ST_OVERFLOW;
          else holds_q[m] = holds_q[m] + 1'b1;
          r.hold_count = holds_q[m];
        end else if (owner_q[m] == 0) begin
          owner_q[m] = t;
          holds_q[m] = COUNT_W'(1);
          r.hold_count = COUNT_W'(1);
        end else begin
          lock_pend_q[t] = m;
          saved_q[t] = COUNT_W'(1);
          r.status = ST_QUEUED;
          r.hold_count = holds_q[m];
        end
      end else if (owner_q[m] != t) begin
        r.status = ST_NOT_OWNER;
        r.hold_count = holds_q[m];
      end else if (cmd == CMD_EXIT) begin
        if (holds_q[m] == 0) r.status = ST_UNDERFLOW;
        else begin
          holds_q[m] = holds_q[m] - 1'b1;
          if (holds_q[m] == 0) owner_q[m] = '0;
          r.hold_count = holds_q[m];
        end
      end else if (cmd == CMD_WAIT) begin
        r.released_count = holds_q[m];
        saved_q[t] = holds_q[m];
        notify_pend_q[t] = m;
        owner_q[m] = '0;
        holds_q[m] = '0;
      end else begin
        // notify walks slots from the top down
        moved = '0;
        for (int i = 15; i >= 0; i--) begin
          if (notify_pend_q[i] == m) begin
            notify_pend_q[i] = '0;
            lock_pend_q[i] = m;
            if (moved != '1) moved = moved + 1'b1;
            if (cmd == CMD_NOT_ONE) break;
          end
        end
        r.hold_count = holds_q[m];
        r.notified_count = moved;
      end
      pending_rsp_q.push_back(r);
    endfunction

    // compare one response with the oldest prediction
    function void check_response(lock_rsp_t act);
      lock_rsp_t exp_r;
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected response %h", $realtime, act);
        errors++;
        return;
      end
      exp_r = pending_rsp_q.pop_front();
      if (exp_r.status != act.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, act.status);
        errors++;
      end
      if (exp_r.hold_count != act.hold_count) begin
        $display("%0t: hold_count exp %0d got %0d", $realtime, exp_r.hold_count,
                 act.hold_count);
        errors++;
      end
      if (exp_r.notified_count != act.notified_count) begin
        $display("%0t: notified_count exp %0d got %0d", $realtime,
                 exp_r.notified_count, act.notified_count);
        errors++;
      end
      if (exp_r.released_count != act.released_count) begin
        $display("%0t: released_count exp %0d got %0d", $realtime,
                 exp_r.released_count, act.released_count);
        errors++;
      end
    endfunction
  endclass
endpackage

>>> verif/tb_reentrant_monitor_lock_unit.sv
// tb_reentrant_monitor_lock_unit: directed and random lock traffic with random stalls
// depends on rmlu_pkg, the rmlu interfaces, rmlu_scoreboard_pkg and the unit itself
`timescale 1ns / 100ps

module tb_reentrant_monitor_lock_unit;
  import rmlu_pkg::*;
  import rmlu_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  rmlu_req_if req_if ();
  rmlu_rsp_if rsp_if ();
  lock_scoreboard lock_sb = new();
  bit   long_stall = 1'b0;
  bit   stim_done = 1'b0;
  int   idle_cycles = 0;
  logic [TID_W-1:0] busy_tid;

  reentrant_monitor_lock_unit uut (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req_if.sink), .rsp_o (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.command = '0;
    req_if.thread_id = '0;
    req_if.monitor_id = '0;
    rsp_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // offer one request item and wait for its acceptance; valid stays high
  // afterwards so that a request with no gap follows without a bubble
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] t,
                              logic [MID_W-1:0] m, int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.thread_id <= t;
    req_if.monitor_id <= m;
    do @(posedge clk_i); while (!req_if.ready);
    lock_sb.note_request(cmd, t, m);
  endtask

  // random lock requests on few threads and monitors, with some noise over the whole field ranges
  task automatic random_request();
    logic [CMD_W-1:0] cmd;
    logic [TID_W-1:0] t;
    logic [MID_W-1:0] m;
    int sel;
    sel = $urandom_range(0, 99);
    t = TID_W'($urandom_range(1, 6));
    m = MID_W'($urandom_range(1, 4));
    if (sel < 30) cmd = CMD_ENTER;
    else if (sel < 48) cmd = CMD_EXIT;
    else if (sel < 58) cmd = CMD_WAIT;
    else if (sel < 68) cmd = CMD_NOT_ONE;
    else if (sel < 74) cmd = CMD_NOT_ALL;
    else if (sel < 90) cmd = CMD_TRY;
    else begin
      // noise over the whole field ranges
      cmd = CMD_W'($urandom_range(0, 7));
      t = TID_W'($urandom_range(0, 15));
      m = MID_W'($urandom_range(0, 255));
    end
    send_request(cmd, t, m, $urandom_range(0, 12));
  endtask

  // stimulus
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    // directed: every command, reserved ids, unknown codes, extremes
    send_request(CMD_TRY, 4'd15, 8'd255, 0);
    send_request(CMD_ENTER, 4'd0, 8'd9, 0);
    send_request(CMD_ENTER, 4'd3, 8'd0, 0);
    send_request(3'd6, 4'd3, 8'd9, 0);
    send_request(3'd7, 4'd15, 8'd255, 0);
    send_request(CMD_EXIT, 4'd1, 8'd255, 0);
    send_request(CMD_ENTER, 4'd15, 8'd255, 0);
    send_request(CMD_ENTER, 4'd15, 8'd255, 0);
    send_request(CMD_ENTER, 4'd1, 8'd255, 0);
    send_request(CMD_WAIT, 4'd2, 8'd255, 0);
    send_request(CMD_NOT_ONE, 4'd1, 8'd255, 0);
    send_request(CMD_ENTER, 4'd1, 8'd255, 0);
    send_request(CMD_TRY, 4'd1, 8'd0, 0);
    send_request(CMD_WAIT, 4'd15, 8'd255, 0);
    send_request(CMD_TRY, 4'd1, 8'd0, 0);
    send_request(CMD_TRY, 4'd15, 8'd0, 0);
    send_request(CMD_ENTER, 4'd2, 8'd7, 0);
    send_request(CMD_WAIT, 4'd2, 8'd7, 0);
    send_request(CMD_ENTER, 4'd4, 8'd7, 0);
    send_request(CMD_WAIT, 4'd4, 8'd7, 0);
    send_request(CMD_ENTER, 4'd5, 8'd7, 0);
    send_request(CMD_NOT_ALL, 4'd5, 8'd7, 0);
    send_request(CMD_NOT_ONE, 4'd5, 8'd7, 0);
    send_request(CMD_EXIT, 4'd5, 8'd7, 0);
    send_request(CMD_EXIT, 4'd5, 8'd7, 0);
    req_if.valid <= 1'b0;
    // sender pause until every response has come
    wait (lock_sb.pending_rsp_q.size() == 0);
    // receiver holds off while the sender keeps offering
    long_stall = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40) long_stall = 1'b1;
      random_request();
    end
    // three nested enters by thread 9 on monitor 200
    busy_tid = 4'd9;
    for (int i = 0; i < 3; i++) send_request(CMD_ENTER, busy_tid, 8'd200, 0);
    req_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // response side with random stalls and long hold-offs
  initial begin
    lock_rsp_t act;
    int stall;
    wait (rst_ni);
    forever begin
      if (long_stall) begin
        rsp_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_stall = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      act.status = rsp_if.status;
      act.hold_count = rsp_if.hold_count;
      act.notified_count = rsp_if.notified_count;
      act.released_count = rsp_if.released_count;
      lock_sb.check_response(act);
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (lock_sb.pending_rsp_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (lock_sb.errors == 0 && lock_sb.pending_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
